[hdl/sst_pkg.sv]
// Package for the scan slot table: entry layout, write controls, codes.
// No dependencies; used by sst_store and scan_slot_table_top.
`default_nettype none

package sst_pkg;

    // Operation codes carried by kind
    localparam logic [2:0] KIND_GRAB   = 3'd0;
    localparam logic [2:0] KIND_FIND   = 3'd1;
    localparam logic [2:0] KIND_UPDATE = 3'd2;
    localparam logic [2:0] KIND_FREE   = 3'd3;
    localparam logic [2:0] KIND_CLEAR  = 3'd4;

    // Result status codes
    localparam logic [2:0] ST_MATCH    = 3'd0;
    localparam logic [2:0] ST_NEW      = 3'd1;
    localparam logic [2:0] ST_REPLACED = 3'd2;
    localparam logic [2:0] ST_NONE     = 3'd3;
    localparam logic [2:0] ST_DONE     = 3'd4;

    localparam logic signed [15:0] LIMIT_RESET = -16'sd8000;

    // Mutable part of an entry
    typedef struct packed {
        logic [15:0]        frequency;
        logic signed [15:0] signal_level;
        logic               stale_mark;
    } sst_data_t;

    // Full entry as seen on a read
    typedef struct packed {
        logic [47:0] station_address;
        sst_data_t   data;
    } sst_entry_t;

    // Write controls from the sequencer to the store
    typedef struct packed {
        logic data_we;
        logic addr_we;
        logic set_valid;
        logic clr_valid;
        logic clr_all;
    } sst_wr_ctrl_t;

endpackage

`default_nettype wire

[hdl/scan_slot_table_top.sv]
// Scan slot table: one transaction at a time, entries read one per cycle from the
// store's single registered read port. Update, clear and unused kinds finish from
// idle; grab and find scan entries up to the count, stopping at a live match, then
// resolve; free clears an in-range slot, then trims trailing free slots off the count.
// done pulses one cycle, receiver cannot stall; busy holds off the next start.
// Reset clears all entries and the count at once and sets the limit to -8000.
`default_nettype none

module scan_slot_table_top #(
    parameter int SLOTS = 64
) (
    input  wire                clk,
    input  wire                rst_n,
    input  wire                weak_signal_limit_we,
    input  wire signed [15:0]  weak_signal_limit,
    input  wire                start,
    output logic               busy,
    input  wire  [2:0]         kind,
    input  wire  [47:0]        station_address,
    input  wire  [5:0]         slot_index,
    input  wire  [15:0]        frequency,
    input  wire signed [15:0]  signal_level,
    input  wire                stale_mark,
    output logic               done,
    output logic [5:0]         result_slot,
    output logic [2:0]         status,
    output logic [6:0]         used_count
);

    localparam int IW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int CW = $clog2(SLOTS + 1);

    typedef enum logic [1:0] {S_IDLE, S_SCAN, S_RESOLVE, S_TRIM} state_t;

    state_t            state_reg, state_next;
    logic [CW-1:0]     cnt_reg, cnt_next;
    logic signed [15:0] limit_reg, limit_next;
    logic [2:0]        kind_reg, kind_next;
    logic [47:0]       addr_reg, addr_next;
    logic [IW-1:0]     idx_reg, idx_next;
    logic [IW-1:0]     rd_idx_reg, rd_idx_next;
    logic [IW-1:0]     chk_idx_reg, chk_idx_next;
    logic              chk_vld_reg, chk_vld_next;
    logic              free_hit_reg, free_hit_next;
    logic [IW-1:0]     free_idx_reg, free_idx_next;
    logic              weak_hit_reg, weak_hit_next;
    logic [IW-1:0]     weak_idx_reg, weak_idx_next;
    logic              done_reg, done_next;
    logic [5:0]        rslot_reg, rslot_next;
    logic [2:0]        status_reg, status_next;
    logic [6:0]        ucnt_reg, ucnt_next;

    sst_pkg::sst_entry_t   rd_entry;
    sst_pkg::sst_wr_ctrl_t wr_ctrl;
    sst_pkg::sst_data_t    wr_data;
    logic [IW-1:0]         wr_idx;
    logic [SLOTS-1:0]      occupied;

    logic [IW-1:0] last_idx;
    logic          in_range;
    logic          hit_match, hit_free, hit_weak;

    sst_store #(.SLOTS(SLOTS)) u_store (
        .clk      (clk),
        .rst_n    (rst_n),
        .rd_idx   (rd_idx_reg),
        .rd_entry (rd_entry),
        .wr_idx   (wr_idx),
        .wr_ctrl  (wr_ctrl),
        .wr_addr  (addr_reg),
        .wr_data  (wr_data),
        .occupied (occupied)
    );

    assign last_idx  = IW'(cnt_reg - CW'(1));
    assign in_range  = (9'(slot_index) < 9'(SLOTS));
    assign hit_match = (rd_entry.data.frequency != 16'd0)
                    && (rd_entry.station_address == addr_reg);
    assign hit_free  = !occupied[chk_idx_reg];
    assign hit_weak  = rd_entry.data.stale_mark
                    && (rd_entry.data.signal_level <= limit_reg);

    // Sequencer: scan, resolve, trim and register the result
    always_comb
    begin
        state_next    = state_reg;
        cnt_next      = cnt_reg;
        limit_next    = limit_reg;
        kind_next     = kind_reg;
        addr_next     = addr_reg;
        idx_next      = idx_reg;
        rd_idx_next   = rd_idx_reg;
        chk_idx_next  = chk_idx_reg;
        chk_vld_next  = 1'b0;
        free_hit_next = free_hit_reg;
        free_idx_next = free_idx_reg;
        weak_hit_next = weak_hit_reg;
        weak_idx_next = weak_idx_reg;
        done_next     = 1'b0;
        rslot_next    = rslot_reg;
        status_next   = status_reg;
        ucnt_next     = ucnt_reg;
        wr_ctrl       = '0;
        wr_data       = '0;
        wr_idx        = idx_reg;

        if (weak_signal_limit_we)
        begin
            limit_next = weak_signal_limit;
        end

        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    kind_next     = kind;
                    addr_next     = station_address;
                    idx_next      = IW'(slot_index);
                    rd_idx_next   = '0;
                    free_hit_next = 1'b0;
                    weak_hit_next = 1'b0;
                    case (kind)
                        sst_pkg::KIND_GRAB, sst_pkg::KIND_FIND:
                        begin
                            state_next = (cnt_reg == '0) ? S_RESOLVE : S_SCAN;
                        end
                        sst_pkg::KIND_UPDATE:
                        begin
                            done_next  = 1'b1;
                            rslot_next = slot_index;
                            ucnt_next  = 7'(cnt_reg);
                            wr_idx     = IW'(slot_index);
                            if (in_range && occupied[IW'(slot_index)])
                            begin
                                wr_ctrl.data_we      = 1'b1;
                                wr_data.frequency    = frequency;
                                wr_data.signal_level = signal_level;
                                wr_data.stale_mark   = stale_mark;
                                status_next          = sst_pkg::ST_DONE;
                            end
                            else
                            begin
                                status_next = sst_pkg::ST_NONE;
                            end
                        end
                        sst_pkg::KIND_FREE:
                        begin
                            rslot_next = slot_index;
                            wr_idx     = IW'(slot_index);
                            if (in_range)
                            begin
                                wr_ctrl.clr_valid = 1'b1;
                                state_next        = S_TRIM;
                            end
                            else
                            begin
                                done_next   = 1'b1;
                                status_next = sst_pkg::ST_NONE;
                                ucnt_next   = 7'(cnt_reg);
                            end
                        end
                        sst_pkg::KIND_CLEAR:
                        begin
                            wr_ctrl.clr_all = 1'b1;
                            cnt_next        = '0;
                            done_next       = 1'b1;
                            rslot_next      = 6'd0;
                            status_next     = sst_pkg::ST_DONE;
                            ucnt_next       = 7'd0;
                        end
                        default:
                        begin
                            done_next   = 1'b1;
                            rslot_next  = 6'd0;
                            status_next = sst_pkg::ST_NONE;
                            ucnt_next   = 7'(cnt_reg);
                        end
                    endcase
                end
            end

            S_SCAN:
            begin
                // Issue the next read, check the entry read last cycle
                if (!chk_vld_reg || (chk_idx_reg != last_idx))
                begin
                    chk_idx_next = rd_idx_reg;
                    chk_vld_next = 1'b1;
                    if (rd_idx_reg != last_idx)
                    begin
                        rd_idx_next = rd_idx_reg + IW'(1);
                    end
                end
                if (chk_vld_reg)
                begin
                    if (hit_match)
                    begin
                        done_next   = 1'b1;
                        rslot_next  = 6'(chk_idx_reg);
                        status_next = sst_pkg::ST_MATCH;
                        ucnt_next   = 7'(cnt_reg);
                        state_next  = S_IDLE;
                    end
                    else
                    begin
                        if (hit_free && !free_hit_reg)
                        begin
                            free_hit_next = 1'b1;
                            free_idx_next = chk_idx_reg;
                        end
                        if (hit_weak && !weak_hit_reg)
                        begin
                            weak_hit_next = 1'b1;
                            weak_idx_next = chk_idx_reg;
                        end
                        if (chk_idx_reg == last_idx)
                        begin
                            state_next = S_RESOLVE;
                        end
                    end
                end
            end

            S_RESOLVE:
            begin
                // For a grab: pick a free slot, extend the count or replace a weak entry
                done_next   = 1'b1;
                state_next  = S_IDLE;
                rslot_next  = 6'd0;
                status_next = sst_pkg::ST_NONE;
                ucnt_next   = 7'(cnt_reg);
                if (kind_reg == sst_pkg::KIND_GRAB)
                begin
                    if (free_hit_reg)
                    begin
                        wr_idx      = free_idx_reg;
                        rslot_next  = 6'(free_idx_reg);
                        status_next = sst_pkg::ST_NEW;
                    end
                    else if (cnt_reg < CW'(SLOTS))
                    begin
                        wr_idx      = IW'(cnt_reg);
                        rslot_next  = 6'(cnt_reg);
                        status_next = sst_pkg::ST_NEW;
                        cnt_next    = cnt_reg + CW'(1);
                        ucnt_next   = 7'(cnt_reg + CW'(1));
                    end
                    else if (weak_hit_reg)
                    begin
                        wr_idx      = weak_idx_reg;
                        rslot_next  = 6'(weak_idx_reg);
                        status_next = sst_pkg::ST_REPLACED;
                    end
                    if (status_next != sst_pkg::ST_NONE)
                    begin
                        wr_ctrl.data_we   = 1'b1;
                        wr_ctrl.addr_we   = 1'b1;
                        wr_ctrl.set_valid = 1'b1;
                    end
                end
            end

            S_TRIM:
            begin
                // Drop trailing free slots, one per cycle
                if ((cnt_reg != '0) && !occupied[last_idx])
                begin
                    cnt_next = cnt_reg - CW'(1);
                end
                else
                begin
                    done_next   = 1'b1;
                    status_next = sst_pkg::ST_DONE;
                    ucnt_next   = 7'(cnt_reg);
                    state_next  = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            cnt_reg      <= '0;
            limit_reg    <= sst_pkg::LIMIT_RESET;
            kind_reg     <= '0;
            addr_reg     <= '0;
            idx_reg      <= '0;
            rd_idx_reg   <= '0;
            chk_idx_reg  <= '0;
            chk_vld_reg  <= 1'b0;
            free_hit_reg <= 1'b0;
            free_idx_reg <= '0;
            weak_hit_reg <= 1'b0;
            weak_idx_reg <= '0;
            done_reg     <= 1'b0;
            rslot_reg    <= '0;
            status_reg   <= '0;
            ucnt_reg     <= '0;
        end
        else
        begin
            state_reg    <= state_next;
            cnt_reg      <= cnt_next;
            limit_reg    <= limit_next;
            kind_reg     <= kind_next;
            addr_reg     <= addr_next;
            idx_reg      <= idx_next;
            rd_idx_reg   <= rd_idx_next;
            chk_idx_reg  <= chk_idx_next;
            chk_vld_reg  <= chk_vld_next;
            free_hit_reg <= free_hit_next;
            free_idx_reg <= free_idx_next;
            weak_hit_reg <= weak_hit_next;
            weak_idx_reg <= weak_idx_next;
            done_reg     <= done_next;
            rslot_reg    <= rslot_next;
            status_reg   <= status_next;
            ucnt_reg     <= ucnt_next;
        end
    end

    assign busy        = (state_reg != S_IDLE);
    assign done        = done_reg;
    assign result_slot = rslot_reg;
    assign status      = status_reg;
    assign used_count  = ucnt_reg;

    // Checks
    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !busy) else $error("result while busy");

    a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= CW'(SLOTS)) else $error("count past table size");

    a_clear: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && kind == sst_pkg::KIND_CLEAR) |=>
        (done && used_count == 7'd0)) else $error("clear result wrong");

    a_new_cnt: assert property (@(posedge clk) disable iff (!rst_n)
        (done && status == sst_pkg::ST_NEW) |-> (cnt_reg != '0))
        else $error("new slot with empty count");

endmodule

`default_nettype wire

[hdl/sst_store.sv]
// Entry store of the scan slot table: address and data memories, occupied bits.
// Depends on sst_pkg.
`default_nettype none

module sst_store #(
    parameter int SLOTS = 64,
    localparam int IW = (SLOTS > 1) ? $clog2(SLOTS) : 1
) (
    input  wire                         clk,
    input  wire                         rst_n,
    input  wire  [IW-1:0]               rd_idx,
    output sst_pkg::sst_entry_t         rd_entry,
    input  wire  [IW-1:0]               wr_idx,
    input  sst_pkg::sst_wr_ctrl_t       wr_ctrl,
    input  wire  [47:0]                 wr_addr,
    input  sst_pkg::sst_data_t          wr_data,
    output logic [SLOTS-1:0]            occupied
);

    logic [47:0]        mem_addr [SLOTS];
    sst_pkg::sst_data_t mem_data [SLOTS];

    logic [SLOTS-1:0]   valid_reg;
    logic               rd_valid_reg;
    logic [47:0]        rd_addr_reg;
    sst_pkg::sst_data_t rd_data_reg;

    // Occupied bits: set and cleared per slot, cleared at once by reset or a table clear
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg    <= '0;
            rd_valid_reg <= 1'b0;
        end
        else
        begin
            rd_valid_reg <= valid_reg[rd_idx];
            if (wr_ctrl.clr_all)
            begin
                valid_reg <= '0;
            end
            else if (wr_ctrl.set_valid)
            begin
                valid_reg[wr_idx] <= 1'b1;
            end
            else if (wr_ctrl.clr_valid)
            begin
                valid_reg[wr_idx] <= 1'b0;
            end
        end
    end

    // Memories: one write port, one registered read port each
    always_ff @(posedge clk)
    begin
        if (wr_ctrl.data_we)
        begin
            mem_data[wr_idx] <= wr_data;
        end
        if (wr_ctrl.addr_we)
        begin
            mem_addr[wr_idx] <= wr_addr;
        end
        rd_addr_reg <= mem_addr[rd_idx];
        rd_data_reg <= mem_data[rd_idx];
    end

    // Unoccupied entries read as zero
    always_comb
    begin
        rd_entry = '0;
        if (rd_valid_reg)
        begin
            rd_entry.station_address = rd_addr_reg;
            rd_entry.data            = rd_data_reg;
        end
    end

    assign occupied = valid_reg;

endmodule

`default_nettype wire
